// ===== rtl/wwvb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed wavetable voice bank package
// Shared constants, command and register codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package wwvb_pkg;

  localparam int DEF_VOICES       = 8;
  localparam int DEF_DIVISIONS    = 8;
  localparam int DEF_WAVE_DEPTH   = 4096;
  localparam int DEF_WINDOW_DEPTH = 4096;

  localparam int FRAC_BITS = 20;
  localparam int TAB_W     = 22;
  localparam int MA_W      = 34;
  localparam int MB_W      = 24;
  localparam int P_W       = MA_W + MB_W;
  localparam int MOD_STEPS = 9;
  localparam int RED_W     = 45;
  localparam int QUOT_W    = 22;
  localparam int STEP_W    = 5;
  localparam int ACC_W     = 30;
  localparam int OUT_W     = 25;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam longint Q30_ONE     = 64'sd1 << 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam int     OUT_MAX     = 16777215;
  localparam int     OUT_MIN     = -16777216;

  localparam logic [23:0] RST_CYCLE_LENGTH     = 24'd4096000;
  localparam logic [15:0] RST_BLOCK_LENGTH     = 16'd1486;
  localparam logic [23:0] RST_DIVISION_SPACING = 24'd1024000;
  localparam logic [3:0]  RST_DIVISION_COUNT   = 4'd4;
  localparam logic [31:0] RST_WINDOW_STEP      = 32'd1947825;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_BLOCK  = 2'd1,
    CMD_LOAD   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYCLE_LENGTH     = 3'd0,
    REG_BLOCK_LENGTH     = 3'd1,
    REG_DIVISION_SPACING = 3'd2,
    REG_DIVISION_COUNT   = 3'd3,
    REG_WINDOW_STEP      = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RA,
    ST_RB,
    ST_RC,
    ST_M1,
    ST_M2,
    ST_MWIN,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_WMOD,
    ST_HMOD,
    ST_HUPD,
    ST_DIV,
    ST_OUT,
    ST_BSTART,
    ST_BLOOP,
    ST_LDEC,
    ST_LINC
  } state_t;

endpackage

// ===== rtl/wwvb_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable ROM
// Cosine or Hann table of DEPTH+1 Q1.20 entries with a registered read port.
// ----------------------------------------------------------------------------
module wwvb_rom #(
  parameter int DEPTH = wwvb_pkg::DEF_WAVE_DEPTH,
  parameter bit HANN  = 1'b0
) (
  input  logic                               clk,
  input  logic [$clog2(DEPTH+1)-1:0]         addr,
  output logic signed [wwvb_pkg::TAB_W-1:0]  data
);
  import wwvb_pkg::*;

  logic signed [TAB_W-1:0] rom [0:DEPTH];

  function automatic longint cos_q30(input longint i);
    longint r;
    longint quad;
    longint rem;
    longint x;
    longint x2;
    longint t;
    r    = 4 * i;
    quad = r / DEPTH;
    rem  = r % DEPTH;
    if (quad[0]) begin
      rem = DEPTH - rem;
    end
    x  = (HALF_PI_Q30 * rem) / DEPTH;
    x2 = (x * x) >>> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 182;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 132;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 90;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 56;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 30;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 12;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 2;
    if (quad[1:0] == 2'd1 || quad[1:0] == 2'd2) begin
      t = -t;
    end
    return t;
  endfunction

  function automatic logic signed [TAB_W-1:0] entry(input longint i);
    longint c;
    c = cos_q30(i);
    if (HANN) begin
      return TAB_W'((Q30_ONE - c + 64'sd1024) >>> 11);
    end
    return TAB_W'((c + 64'sd512) >>> 10);
  endfunction

  for (genvar g = 0; g <= DEPTH; g++) begin : g_rom
    localparam logic signed [TAB_W-1:0] VAL = entry(g);
    assign rom[g] = VAL;
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule

// ===== rtl/windowed_wavetable_voice_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed wavetable voice bank
// Bank of cosine wavetable voices shaped by a Hann window, with block-driven
// division wake-up and per-voice ratio loading.
// ----------------------------------------------------------------------------
//  Channel  Signals                        Direction  Request
//  in       in_valid / in_stall + fields   sink       cmd and its operands
//  out      out_valid / out_stall          source     sample_out, one per sample
//  cfg      cfg_write, cfg_index, cfg_data sink       register write
//
// A sample request scans the voices; each active voice passes in turn through
// the shared multiplier, the modulo reducer and the bit-serial divider. A
// block request advances the position and, unless it wraps, steps through the
// divisions; a load request lowers the old division count, then raises the new.
// Reset is synchronous and clears all voice state. A finished sample waits in
// the output register, and the next request is taken meanwhile; the block
// stalls only if a new sample completes while the previous one is still held.
module windowed_wavetable_voice_bank #(
  parameter int VOICES             = wwvb_pkg::DEF_VOICES,
  parameter int DIVISIONS          = wwvb_pkg::DEF_DIVISIONS,
  parameter int WAVE_TABLE_DEPTH   = wwvb_pkg::DEF_WAVE_DEPTH,
  parameter int WINDOW_TABLE_DEPTH = wwvb_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [wwvb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wwvb_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           cmd,
  input  logic [31:0]                          root_step,
  input  logic [2:0]                           voice_index,
  input  logic [15:0]                          voice_ratio,
  input  logic [2:0]                           voice_division,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [wwvb_pkg::OUT_W-1:0]    sample_out
);
  import wwvb_pkg::*;

  localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VC_W   = $clog2(VOICES + 1);
  localparam int DIV_W  = (DIVISIONS > 1) ? $clog2(DIVISIONS) : 1;
  localparam int DC_W   = $clog2(DIVISIONS + 1);
  localparam int CNT_W  = $clog2(VOICES + 1);
  localparam int WIDX_W = $clog2(WAVE_TABLE_DEPTH);
  localparam int HIDX_W = $clog2(WINDOW_TABLE_DEPTH);
  localparam int WPH_W  = WIDX_W + FRAC_BITS;
  localparam int HPH_W  = HIDX_W + FRAC_BITS;
  localparam int WA_W   = $clog2(WAVE_TABLE_DEPTH + 1);
  localparam int HA_W   = $clog2(WINDOW_TABLE_DEPTH + 1);
  localparam logic [RED_W-1:0] WAVE_MOD = RED_W'(WAVE_TABLE_DEPTH) << FRAC_BITS;
  localparam logic [RED_W-1:0] WIN_MOD  = RED_W'(WINDOW_TABLE_DEPTH) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(OUT_MIN);

  state_t st;
  state_t st_next;

  logic [23:0] cycle_length;
  logic [15:0] block_length;
  logic [23:0] division_spacing;
  logic [3:0]  division_count;
  logic [31:0] window_step;

  logic [WPH_W-1:0] wave_phase   [VOICES];
  logic [HPH_W-1:0] hann_phase   [VOICES];
  logic [15:0]      ratio_store  [VOICES];
  logic [DIV_W-1:0] div_store    [VOICES];
  logic [CNT_W-1:0] div_count    [DIVISIONS];
  logic [VOICES-1:0] active;
  logic [VOICES-1:0] assigned;
  logic [23:0]       pos;

  logic [31:0] root_r;
  logic [2:0]  vidx_r;
  logic [15:0] vratio_r;
  logic [2:0]  vdiv_r;

  logic [VC_W-1:0] vcnt;
  logic [VW-1:0]   vi;
  logic [VW-1:0]   vx;
  logic [DIV_W-1:0] ld;

  logic [WA_W-1:0] wave_addr;
  logic [HA_W-1:0] hann_addr;
  logic signed [TAB_W-1:0] wave_data;
  logic signed [TAB_W-1:0] hann_data;
  logic signed [TAB_W-1:0] wa;
  logic signed [TAB_W-1:0] wb;
  logic signed [TAB_W-1:0] ha;
  logic signed [TAB_W-1:0] hb;
  logic signed [TAB_W:0]   wdiff;
  logic signed [TAB_W:0]   hdiff;
  logic signed [TAB_W-1:0] osc;
  logic signed [TAB_W-1:0] win;

  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [P_W-1:0]  prod;
  logic                   pneg;
  logic [P_W-1:0]         pabs;

  logic [RED_W-1:0]  red;
  logic [RED_W-1:0]  modsh;
  logic [RED_W-1:0]  red_next;
  logic              stop;
  logic [STEP_W-1:0] cnt;

  logic [QUOT_W-1:0] dq;
  logic [QUOT_W-1:0] dq_next;
  logic [CNT_W:0]    drem;
  logic [CNT_W:0]    drem_next;
  logic [CNT_W:0]    den;
  logic [CNT_W:0]    trial;
  logic              qbit;
  logic              dneg;
  logic signed [ACC_W-1:0] qext;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sat;

  logic [24:0]     nxt;
  logic [25:0]     lim;
  logic [23:0]     prev;
  logic [29:0]     start;
  logic [DC_W-1:0] dcnt;
  logic [7:0]      ndiv;
  logic            bl_done;
  logic            bl_hit;
  logic            wrap;
  logic            out_load;

  function automatic logic [DIV_W-1:0] div_wrap(input logic [2:0] d);
    logic [7:0] r;
    r = 8'(d);
    for (int k = 0; k < 8; k++) begin
      if (r >= 8'(DIVISIONS)) begin
        r = r - 8'(DIVISIONS);
      end
    end
    return DIV_W'(r);
  endfunction

  wwvb_rom #(.DEPTH(WAVE_TABLE_DEPTH), .HANN(1'b0)) u_wave_rom (
    .clk  (clk),
    .addr (wave_addr),
    .data (wave_data)
  );

  wwvb_rom #(.DEPTH(WINDOW_TABLE_DEPTH), .HANN(1'b1)) u_hann_rom (
    .clk  (clk),
    .addr (hann_addr),
    .data (hann_data)
  );

  assign vi       = vcnt[VW-1:0];
  assign vx       = VW'(vidx_r);
  assign ld       = div_wrap(vdiv_r);
  assign in_stall = (st != ST_IDLE);
  assign out_load = (st == ST_OUT) && (!out_valid || !out_stall);

  assign wave_addr = (st == ST_RB) ? WA_W'(wave_phase[vi][WPH_W-1:FRAC_BITS]) + WA_W'(1)
                                   : WA_W'(wave_phase[vi][WPH_W-1:FRAC_BITS]);
  assign hann_addr = (st == ST_RB) ? HA_W'(hann_phase[vi][HPH_W-1:FRAC_BITS]) + HA_W'(1)
                                   : HA_W'(hann_phase[vi][HPH_W-1:FRAC_BITS]);

  assign wdiff = wb - wa;
  assign hdiff = hb - ha;
  assign pneg  = prod[P_W-1];
  assign pabs  = pneg ? P_W'(-prod) : P_W'(prod);

  assign modsh    = ((st == ST_WMOD) ? WAVE_MOD : WIN_MOD) << cnt;
  assign red_next = (red >= modsh) ? red - modsh : red;
  assign stop     = ((RED_W+1)'(red) + (RED_W+1)'(window_step)) >= (RED_W+1)'(WIN_MOD);

  assign trial     = {drem[CNT_W-1:0], dq[QUOT_W-1]};
  assign qbit      = (trial >= den);
  assign drem_next = qbit ? trial - den : trial;
  assign dq_next   = {dq[QUOT_W-2:0], qbit};
  assign qext      = ACC_W'(dq_next);
  assign term      = dneg ? -qext : qext;

  assign sat = (acc > ACC_MAX) ? ACC_MAX : ((acc < ACC_MIN) ? ACC_MIN : acc);

  assign nxt     = 25'(pos) + 25'(block_length);
  assign wrap    = (nxt >= 25'(cycle_length));
  assign ndiv    = (8'(division_count) > 8'(DIVISIONS)) ? 8'(DIVISIONS) : 8'(division_count);
  assign bl_done = (8'(dcnt) >= ndiv);
  assign bl_hit  = (start > 30'(prev)) && (start < 30'(lim));

  always_comb begin
    ma = '0;
    mb = '0;
    case (st)
      ST_M1: begin
        ma = MA_W'(wdiff);
        mb = MB_W'({1'b0, wave_phase[vi][FRAC_BITS-1:0]});
      end
      ST_M2: begin
        ma = MA_W'(hdiff);
        mb = MB_W'({1'b0, hann_phase[vi][FRAC_BITS-1:0]});
      end
      ST_M3: begin
        ma = MA_W'(osc);
        mb = MB_W'(win);
      end
      ST_M4: begin
        ma = MA_W'({1'b0, root_r});
        mb = MB_W'({1'b0, ratio_store[vi]});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_SAMPLE: st_next = ST_SCAN;
            CMD_BLOCK:  st_next = ST_BSTART;
            CMD_LOAD:   st_next = ST_LDEC;
            default:    st_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (vcnt == VC_W'(VOICES)) begin
          st_next = ST_OUT;
        end else if (active[vi]) begin
          st_next = ST_RA;
        end
      end
      ST_RA:   st_next = ST_RB;
      ST_RB:   st_next = ST_RC;
      ST_RC:   st_next = ST_M1;
      ST_M1:   st_next = ST_M2;
      ST_M2:   st_next = ST_MWIN;
      ST_MWIN: st_next = ST_M3;
      ST_M3:   st_next = ST_M4;
      ST_M4:   st_next = ST_M5;
      ST_M5:   st_next = ST_WMOD;
      ST_WMOD: begin
        if (cnt == '0) begin
          st_next = ST_HMOD;
        end
      end
      ST_HMOD: begin
        if (cnt == '0) begin
          st_next = ST_HUPD;
        end
      end
      ST_HUPD: st_next = ST_DIV;
      ST_DIV: begin
        if (cnt == '0) begin
          st_next = ST_SCAN;
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          st_next = ST_IDLE;
        end
      end
      ST_BSTART: st_next = wrap ? ST_IDLE : ST_BLOOP;
      ST_BLOOP: begin
        if (bl_done) begin
          st_next = ST_IDLE;
        end
      end
      ST_LDEC: begin
        if (8'(vidx_r) >= 8'(VOICES)) begin
          st_next = ST_IDLE;
        end else begin
          st_next = ST_LINC;
        end
      end
      ST_LINC: st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st == ST_IDLE) begin
      root_r   <= root_step;
      vidx_r   <= voice_index;
      vratio_r <= voice_ratio;
      vdiv_r   <= voice_division;
      vcnt     <= '0;
      acc      <= '0;
    end
    prod <= ma * mb;
    case (st)
      ST_SCAN: begin
        if (vcnt != VC_W'(VOICES) && !active[vi]) begin
          vcnt <= vcnt + VC_W'(1);
        end
      end
      ST_RB: begin
        wa <= wave_data;
        ha <= hann_data;
      end
      ST_RC: begin
        wb <= wave_data;
        hb <= hann_data;
      end
      ST_M2:   osc <= TAB_W'(P_W'(wa) + (prod >>> FRAC_BITS));
      ST_MWIN: win <= TAB_W'(P_W'(ha) + (prod >>> FRAC_BITS));
      ST_M4: begin
        dq   <= pabs[FRAC_BITS +: QUOT_W];
        dneg <= pneg;
        drem <= '0;
        den  <= (CNT_W+1)'(div_count[div_store[vi]]) + (CNT_W+1)'(1);
      end
      ST_M5: begin
        red <= RED_W'(wave_phase[vi]) + RED_W'(prod[47:14]);
        cnt <= STEP_W'(MOD_STEPS - 1);
      end
      ST_WMOD: begin
        if (cnt == '0) begin
          red <= RED_W'(hann_phase[vi]) + RED_W'(window_step);
          cnt <= STEP_W'(MOD_STEPS - 1);
        end else begin
          red <= red_next;
          cnt <= cnt - STEP_W'(1);
        end
      end
      ST_HMOD: begin
        red <= red_next;
        cnt <= cnt - STEP_W'(1);
      end
      ST_HUPD: cnt <= STEP_W'(QUOT_W - 1);
      ST_DIV: begin
        dq   <= dq_next;
        drem <= drem_next;
        cnt  <= cnt - STEP_W'(1);
        if (cnt == '0) begin
          acc  <= acc + term;
          vcnt <= vcnt + VC_W'(1);
        end
      end
      ST_BSTART: begin
        lim   <= 26'(nxt) + 26'(block_length);
        prev  <= pos;
        dcnt  <= '0;
        start <= '0;
      end
      ST_BLOOP: begin
        start <= start + 30'(division_spacing);
        dcnt  <= dcnt + DC_W'(1);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      sample_out <= OUT_W'(sat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_length     <= RST_CYCLE_LENGTH;
      block_length     <= RST_BLOCK_LENGTH;
      division_spacing <= RST_DIVISION_SPACING;
      division_count   <= RST_DIVISION_COUNT;
      window_step      <= RST_WINDOW_STEP;
      active           <= '0;
      assigned         <= '0;
      pos              <= '0;
      out_valid        <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        wave_phase[i]  <= '0;
        hann_phase[i]  <= '0;
        ratio_store[i] <= '0;
        div_store[i]   <= '0;
      end
      for (int j = 0; j < DIVISIONS; j++) begin
        div_count[j] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CYCLE_LENGTH:     cycle_length     <= cfg_data[23:0];
          REG_BLOCK_LENGTH:     block_length     <= cfg_data[15:0];
          REG_DIVISION_SPACING: division_spacing <= cfg_data[23:0];
          REG_DIVISION_COUNT:   division_count   <= cfg_data[3:0];
          REG_WINDOW_STEP:      window_step      <= cfg_data[31:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_WMOD: begin
          if (cnt == '0) begin
            wave_phase[vi] <= red_next[WPH_W-1:0];
          end
        end
        ST_HUPD: begin
          if (stop) begin
            active[vi]     <= 1'b0;
            hann_phase[vi] <= '0;
          end else begin
            hann_phase[vi] <= red[HPH_W-1:0];
          end
        end
        ST_BSTART: begin
          if (wrap) begin
            pos <= '0;
            for (int i = 0; i < VOICES; i++) begin
              if (assigned[i] && div_store[i] == '0) begin
                active[i] <= 1'b1;
              end
            end
          end else begin
            pos <= nxt[23:0];
          end
        end
        ST_BLOOP: begin
          if (!bl_done && bl_hit) begin
            for (int i = 0; i < VOICES; i++) begin
              if (assigned[i] && div_store[i] == dcnt[DIV_W-1:0]) begin
                active[i] <= 1'b1;
              end
            end
          end
        end
        ST_LDEC: begin
          if (8'(vidx_r) < 8'(VOICES) && assigned[vx] &&
              div_count[div_store[vx]] != '0) begin
            div_count[div_store[vx]] <= div_count[div_store[vx]] - CNT_W'(1);
          end
        end
        ST_LINC: begin
          div_count[ld]   <= div_count[ld] + CNT_W'(1);
          div_store[vx]   <= ld;
          ratio_store[vx] <= vratio_r;
          assigned[vx]    <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== bench/tb_windowed_wavetable_voice_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed wavetable voice bank testbench
// Drives sample, block, load and unknown requests with random idling on both
// channels, predicts every output sample from its own copy of the voice bank,
// and checks each sample as it leaves the block.
// ----------------------------------------------------------------------------
module tb_windowed_wavetable_voice_bank;
  import wwvb_pkg::*;

  localparam int NV         = 8;
  localparam int ND         = 8;
  localparam int QUIET_MAX  = 20000;
  localparam int SETTLE     = 20;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           cmd = CMD_NONE;
  logic [31:0]          root_step = '0;
  logic [2:0]           voice_index = '0;
  logic [15:0]          voice_ratio = '0;
  logic [2:0]           voice_division = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [OUT_W-1:0] sample_out;

  windowed_wavetable_voice_bank dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .root_step(root_step), .voice_index(voice_index),
    .voice_ratio(voice_ratio), .voice_division(voice_division),
    .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out)
  );

  always #10 clk = ~clk;

  // Model of the bank.
  longint cos_tab[0:4096];
  longint hann_tab[0:4096];
  longint m_cycle_len, m_block_len, m_spacing, m_div_count, m_win_step;
  bit [31:0] m_wave_ph[NV];
  bit [31:0] m_win_ph[NV];
  bit        m_active[NV];
  bit        m_assigned[NV];
  bit [15:0] m_ratio[NV];
  bit [2:0]  m_div[NV];
  int        m_div_voices[ND];
  longint    m_position;

  logic signed [OUT_W-1:0] expected_samples[$];
  int  error_count = 0;
  int  quiet = 0;
  bit  idle_on = 1'b1;

  function automatic longint cosine_q30(longint i, longint n);
    longint r, quad, rem, x, x2, t, den;
    r = 4 * i;
    quad = r / n;
    rem = r % n;
    if (quad[0]) rem = n - rem;
    x = (HALF_PI_Q30 * rem) / n;
    x2 = (x * x) >>> 30;
    t = Q30_ONE;
    for (int k = 7; k >= 1; k--) begin
      den = (2 * k - 1) * (2 * k);
      t = Q30_ONE - ((x2 * t) >>> 30) / den;
    end
    if (quad[1:0] == 2'd1 || quad[1:0] == 2'd2) t = -t;
    return t;
  endfunction

  function automatic void build_tables();
    for (int i = 0; i <= 4096; i++) begin
      cos_tab[i] = (cosine_q30(i, 4096) + 512) >>> 10;
      hann_tab[i] = (Q30_ONE - cosine_q30(i, 4096) + 1024) >>> 11;
    end
  endfunction

  function automatic void reset_model();
    m_cycle_len = RST_CYCLE_LENGTH;
    m_block_len = RST_BLOCK_LENGTH;
    m_spacing = RST_DIVISION_SPACING;
    m_div_count = RST_DIVISION_COUNT;
    m_win_step = RST_WINDOW_STEP;
    for (int v = 0; v < NV; v++) begin
      m_wave_ph[v] = '0;
      m_win_ph[v] = '0;
      m_active[v] = 1'b0;
      m_assigned[v] = 1'b0;
      m_ratio[v] = '0;
      m_div[v] = '0;
    end
    for (int d = 0; d < ND; d++) m_div_voices[d] = 0;
    m_position = 0;
  endfunction

  function automatic longint table_lookup(bit hann, bit [31:0] ph);
    longint a, b, frac;
    int idx;
    idx = ph[31:20];
    frac = ph[19:0];
    a = hann ? hann_tab[idx] : cos_tab[idx];
    b = hann ? hann_tab[idx + 1] : cos_tab[idx + 1];
    return a + (((b - a) * frac) >>> 20);
  endfunction

  function automatic logic signed [OUT_W-1:0] mix_sample(bit [31:0] root);
    longint acc, osc, win, den, stop_at, step;
    acc = 0;
    stop_at = 64'sd4294967296 - m_win_step;
    for (int v = 0; v < NV; v++) begin
      if (m_active[v]) begin
        osc = table_lookup(1'b0, m_wave_ph[v]);
        win = table_lookup(1'b1, m_win_ph[v]);
        den = longint'(m_div_voices[m_div[v]] + 1) << 20;
        acc += (osc * win) / den;
        step = (longint'(m_ratio[v]) * longint'(root)) >>> 14;
        m_wave_ph[v] = m_wave_ph[v] + step[31:0];
        m_win_ph[v] = m_win_ph[v] + m_win_step[31:0];
        if (longint'(m_win_ph[v]) >= stop_at) begin
          m_active[v] = 1'b0;
          m_win_ph[v] = '0;
        end
      end
    end
    if (acc > OUT_MAX) acc = OUT_MAX;
    if (acc < OUT_MIN) acc = OUT_MIN;
    return acc[OUT_W-1:0];
  endfunction

  function automatic void wake_division(int d);
    for (int v = 0; v < NV; v++)
      if (m_assigned[v] && m_div[v] == d) m_active[v] = 1'b1;
  endfunction

  function automatic void advance_cycle();
    longint prev, nxt, lim, n;
    prev = m_position;
    nxt = prev + m_block_len;
    if (nxt >= m_cycle_len) begin
      m_position = 0;
      wake_division(0);
    end else begin
      lim = nxt + m_block_len;
      n = (m_div_count < ND) ? m_div_count : ND;
      m_position = nxt;
      for (int d = 0; d < n; d++)
        if (m_spacing * d > prev && m_spacing * d < lim) wake_division(d);
    end
  endfunction

  function automatic void load_voice(bit [2:0] v, bit [15:0] ratio, bit [2:0] d);
    if (m_assigned[v] && m_div_voices[m_div[v]] > 0) m_div_voices[m_div[v]]--;
    m_div_voices[d]++;
    m_div[v] = d;
    m_ratio[v] = ratio;
    m_assigned[v] = 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 20);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) report_mismatch("unexpected sample", sample_out, 0);
        else if (sample_out !== expected_samples[0]) begin
          report_mismatch("sample_out", sample_out, expected_samples[0]);
          void'(expected_samples.pop_front());
        end else void'(expected_samples.pop_front());
      end
    end
  end

  task automatic send_request(cmd_t c, bit [31:0] root, bit [2:0] v, bit [15:0] ratio,
                              bit [2:0] d);
    while (idle_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    root_step <= root;
    voice_index <= v;
    voice_ratio <= ratio;
    voice_division <= d;
    do @(posedge clk); while (in_stall);
    case (c)
      CMD_SAMPLE: expected_samples.push_back(mix_sample(root));
      CMD_BLOCK:  advance_cycle();
      CMD_LOAD:   load_voice(v, ratio, d);
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, longint val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[31:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_CYCLE_LENGTH:     m_cycle_len = val & 64'hFFFFFF;
      REG_BLOCK_LENGTH:     m_block_len = val & 64'hFFFF;
      REG_DIVISION_SPACING: m_spacing = val & 64'hFFFFFF;
      REG_DIVISION_COUNT:   m_div_count = val & 64'hF;
      REG_WINDOW_STEP:      m_win_step = val & 64'hFFFFFFFF;
      default: ;
    endcase
  endtask

  task automatic sample(bit [31:0] root);
    send_request(CMD_SAMPLE, root, 3'($urandom), 16'($urandom), 3'($urandom));
  endtask

  task automatic block();
    send_request(CMD_BLOCK, $urandom, 3'($urandom), 16'($urandom), 3'($urandom));
  endtask

  task automatic load(bit [2:0] v, bit [15:0] ratio, bit [2:0] d);
    send_request(CMD_LOAD, $urandom, v, ratio, d);
  endtask

  task automatic unknown();
    send_request(CMD_NONE, $urandom, 3'($urandom), 16'($urandom), 3'($urandom));
  endtask

  task automatic test_silent_bank();
    sample(32'h0);
    sample(32'hFFFFFFFF);
    unknown();
    block();
    sample($urandom);
  endtask

  task automatic test_wake_and_mix();
    wait_idle();
    write_reg(REG_CYCLE_LENGTH, 3000);
    write_reg(REG_DIVISION_SPACING, 1000);
    write_reg(REG_DIVISION_COUNT, 8);
    load(3'd0, 16'h4000, 3'd0);
    load(3'd7, 16'hFFFF, 3'd7);
    load(3'd3, 16'h0000, 3'd1);
    load(3'd0, 16'h2000, 3'd1);
    load(3'd5, 16'h8000, 3'd0);
    block();
    block();
    block();
    sample(32'h0);
    sample(32'hFFFFFFFF);
    sample(32'h00100000);
    unknown();
    sample($urandom);
  endtask

  task automatic test_window_extremes();
    wait_idle();
    write_reg(REG_WINDOW_STEP, 32'hFFFFFFFF);
    write_reg(REG_CYCLE_LENGTH, 0);
    write_reg(REG_BLOCK_LENGTH, 65535);
    block();
    sample($urandom);
    sample($urandom);
    wait_idle();
    write_reg(REG_WINDOW_STEP, 0);
    write_reg(REG_BLOCK_LENGTH, 1);
    block();
    sample($urandom);
    sample($urandom);
  endtask

  task automatic test_random_phases();
    longint cl;
    int pick;
    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      idle_on = (ph != 4);
      case (ph)
        0: cl = 1;
        1: cl = 24'hFFFFFF;
        default: cl = $urandom_range(20000, 1);
      endcase
      write_reg(REG_CYCLE_LENGTH, cl);
      write_reg(REG_BLOCK_LENGTH, (ph == 2) ? 65535 : $urandom_range(5000, 1));
      write_reg(REG_DIVISION_SPACING, (ph == 3) ? 0 : (ph == 5) ? 24'hFFFFFF
                : cl / $urandom_range(8, 1));
      write_reg(REG_DIVISION_COUNT, (ph == 6) ? 15 : $urandom_range(8, 0));
      case ($urandom_range(3))
        0: write_reg(REG_WINDOW_STEP, $urandom_range(32'h01000000, 32'h00100000));
        1: write_reg(REG_WINDOW_STEP, $urandom_range(32'h40000000, 32'h08000000));
        2: write_reg(REG_WINDOW_STEP, $urandom);
        default: write_reg(REG_WINDOW_STEP, (ph[0]) ? 0 : 32'hFFFFFFFF);
      endcase
      for (int n = 0; n < 72; n++) begin
        if (ph == 7 && n == 36) wait_idle();
        pick = $urandom_range(99);
        if (pick < 60) sample($urandom);
        else if (pick < 78) block();
        else if (pick < 95) load(3'($urandom), 16'($urandom), 3'($urandom));
        else unknown();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    build_tables();
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_silent_bank();
    test_wake_and_mix();
    test_window_extremes();
    test_random_phases();
    wait_idle();
    repeat (50) @(posedge clk);
    if (expected_samples.size() != 0)
      report_mismatch("samples never delivered", 0, expected_samples.size());
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wwvb_pkg.sv
rtl/wwvb_rom.sv
rtl/windowed_wavetable_voice_bank.sv
bench/tb_windowed_wavetable_voice_bank.sv
